FILE: sv/cdq_pkg.sv
// cdq_pkg: command and status codes, channel field widths and ring alu ops
// for the circular deque; no dependencies
package cdq_pkg;

	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 5;
	localparam int FILL_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_INSERT     = 3'd4,
		CMD_READ       = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

FILE: sv/circular_deque.sv
// circular_deque: double-ended queue in a ring memory with a small sequencer
// depends on cdq_pkg and cdq_ring_alu
//
// usage
//   input channel (in_valid/in_stall) carries cmd, wr_value and position; one
//   transfer is one command. output channel (out_valid/out_stall) carries one
//   result per command: rd_value, status, fill_count, full_flag, empty_flag.
// sequence
//   push, clear, unused command and any error: idle, exec, done
//   pop and read: an extra rwait state for the registered memory read
//   insert at the head: same path as push front
//   insert at position p > 0 with n entries: the shift loop moves the n-p
//   entries from p upward, one per read/write state pair (shr, shw), through
//   the single memory port and the shared ring alu
// reset
//   pointers and fill count clear at once, then a sweep writes zero into every
//   ring slot with in_stall high
// backpressure
//   a finished result sits in the output register; the next command is taken
//   meanwhile, and its result waits in the sequencer until the output is free
module circular_deque import cdq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// command channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CMD_W-1:0]          cmd,
	input  logic signed [VALUE_W-1:0] wr_value,
	input  logic [POS_W-1:0]          position,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] rd_value,
	output logic [1:0]                status,
	output logic [FILL_W-1:0]         fill_count,
	output logic                      full_flag,
	output logic                      empty_flag
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_EXEC,
		S_RWAIT,
		S_SHR,
		S_SHW,
		S_INS,
		S_TAIL,
		S_DONE
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [VALUE_W-1:0]   val_q;
	logic [POS_W-1:0]     pos_q;
	logic [AW-1:0]        head_q;
	logic [AW-1:0]        tail_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic [VALUE_W-1:0]   res_rd_q;
	status_t              res_st_q;

	// output register
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   rd_value_q;
	logic [1:0]           status_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 full_q;
	logic                 empty_q;

	// ring memory
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] mem_rdata_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [AW-1:0]         mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata;

	// shared ring alu
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	alu_op_t       alu_op;
	logic [AW-1:0] alu_r;

	logic                         ring_empty;
	logic                         is_full;
	logic                         pos_zero;
	logic                         ins_pos_err;
	logic                         rd_pos_err;
	logic                         do_pf;
	logic                         do_pb;
	logic [CW-1:0]                idx_dec;
	logic [AW-1:0]                pos_a;
	logic [63:0]                  wr_ext;
	logic [DATA_WIDTH-1:0]        wr_word;
	logic signed [DATA_WIDTH-1:0] rdata_s;
	logic signed [63:0]           rd_ext;

	assign ring_empty  = cnt_q == '0;
	assign is_full     = cnt_q == CW'(DEPTH);
	assign pos_zero    = pos_q == '0;
	assign ins_pos_err = 32'(pos_q) > 32'(cnt_q);
	assign rd_pos_err  = 32'(pos_q) >= 32'(DEPTH);
	assign idx_dec     = idx_q - 1'b1;
	assign pos_a       = AW'(pos_q);

	// push front, and insert at the head, share one path
	assign do_pf = !is_full && ((cmd_q == CMD_PUSH_FRONT) ||
		((cmd_q == CMD_INSERT) && !ins_pos_err && pos_zero));
	assign do_pb = !is_full && (cmd_q == CMD_PUSH_BACK);

	// low DATA_WIDTH bits of the zero-extended value are stored
	assign wr_ext  = {32'b0, val_q};
	assign wr_word = wr_ext[DATA_WIDTH-1:0];

	// stored word comes back sign-extended
	assign rdata_s = mem_rdata_q;
	assign rd_ext  = 64'(rdata_s);

	cdq_ring_alu #(
		.DEPTH (DEPTH)
	) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.r  (alu_r)
	);

	// alu operands and memory port control per sequencer step
	always_comb begin
		alu_a     = head_q;
		alu_b     = AW'(1);
		alu_op    = ALU_ADD;
		mem_we    = 1'b0;
		mem_waddr = alu_r;
		mem_raddr = alu_r;
		mem_wdata = wr_word;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = '0;
			end
			S_EXEC: begin
				if (do_pf) begin
					alu_a     = head_q;
					alu_op    = ALU_SUB;
					mem_we    = 1'b1;
					mem_waddr = ring_empty ? '0 : alu_r;
				end else if (do_pb) begin
					alu_a     = tail_q;
					alu_op    = ALU_ADD;
					mem_we    = 1'b1;
					mem_waddr = ring_empty ? '0 : alu_r;
				end else begin
					case (cmd_q)
						CMD_POP_FRONT: begin
							mem_raddr = head_q;
						end
						CMD_POP_BACK: begin
							alu_a     = tail_q;
							alu_op    = ALU_SUB;
							mem_raddr = tail_q;
						end
						CMD_READ: begin
							alu_b = pos_a;
						end
						default: begin
						end
					endcase
				end
			end
			S_SHR: begin
				// fetch logical entry i-1
				alu_b = idx_dec[AW-1:0];
			end
			S_SHW: begin
				// move it up to logical entry i
				alu_b     = idx_q[AW-1:0];
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q;
			end
			S_INS: begin
				alu_b  = pos_a;
				mem_we = 1'b1;
			end
			S_TAIL: begin
				alu_a = tail_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	// sequencer, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cmd_q       <= CMD_CLEAR;
			val_q       <= '0;
			pos_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			res_rd_q    <= '0;
			res_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
			rd_value_q  <= '0;
			status_q    <= '0;
			fill_q      <= '0;
			full_q      <= 1'b0;
			empty_q     <= 1'b1;
		end else begin
			// in S_DONE the hand-over below takes care of the valid bit
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= cmd_t'(cmd);
						val_q    <= wr_value;
						pos_q    <= position;
						res_rd_q <= '0;
						res_st_q <= ST_OK;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (cmd_q)
						CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
							if (is_full) begin
								res_st_q <= ST_FULL;
							end else if (ring_empty) begin
								head_q <= '0;
								tail_q <= '0;
								cnt_q  <= CW'(1);
							end else begin
								if (cmd_q == CMD_PUSH_FRONT) begin
									head_q <= alu_r;
								end else begin
									tail_q <= alu_r;
								end
								cnt_q <= cnt_q + 1'b1;
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK: begin
							if (ring_empty) begin
								res_st_q <= ST_EMPTY;
							end else begin
								if (cnt_q == CW'(1)) begin
									head_q <= '0;
									tail_q <= '0;
								end else if (cmd_q == CMD_POP_FRONT) begin
									head_q <= alu_r;
								end else begin
									tail_q <= alu_r;
								end
								cnt_q   <= cnt_q - 1'b1;
								state_q <= S_RWAIT;
							end
						end
						CMD_INSERT: begin
							if (ins_pos_err) begin
								res_st_q <= ST_RANGE;
							end else if (is_full) begin
								res_st_q <= ST_FULL;
							end else if (pos_zero) begin
								// same as push front
								if (ring_empty) begin
									head_q <= '0;
									tail_q <= '0;
									cnt_q  <= CW'(1);
								end else begin
									head_q <= alu_r;
									cnt_q  <= cnt_q + 1'b1;
								end
							end else begin
								idx_q <= cnt_q;
								if (32'(pos_q) < 32'(cnt_q)) begin
									state_q <= S_SHR;
								end else begin
									state_q <= S_INS;
								end
							end
						end
						CMD_READ: begin
							if (rd_pos_err) begin
								res_st_q <= ST_RANGE;
							end else begin
								state_q <= S_RWAIT;
							end
						end
						CMD_CLEAR: begin
							head_q <= '0;
							tail_q <= '0;
							cnt_q  <= '0;
						end
						default: begin
						end
					endcase
				end
				S_RWAIT: begin
					res_rd_q <= rd_ext[VALUE_W-1:0];
					state_q  <= S_DONE;
				end
				S_SHR: begin
					state_q <= S_SHW;
				end
				S_SHW: begin
					idx_q <= idx_dec;
					if (32'(idx_dec) > 32'(pos_q)) begin
						state_q <= S_SHR;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					state_q <= S_TAIL;
				end
				S_TAIL: begin
					tail_q  <= alu_r;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand the result over once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						rd_value_q  <= res_rd_q;
						status_q    <= res_st_q;
						fill_q      <= FILL_W'(cnt_q);
						full_q      <= is_full;
						empty_q     <= ring_empty;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = state_q != S_IDLE;
	assign out_valid  = out_valid_q;
	assign rd_value   = rd_value_q;
	assign status     = status_q;
	assign fill_count = fill_q;
	assign full_flag  = full_q;
	assign empty_flag = empty_q;

endmodule

FILE: sv/cdq_ring_alu.sv
// cdq_ring_alu: shared modulo-DEPTH adder/subtractor for ring pointers and slots
// depends on cdq_pkg for the operation codes
module cdq_ring_alu import cdq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic [AW-1:0] a,
	input  logic [AW-1:0] b,
	input  alu_op_t       op,
	output logic [AW-1:0] r
);

	localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

	logic [AW:0] sum;
	logic [AW:0] diff;

	always_comb begin
		sum  = {1'b0, a} + {1'b0, b};
		diff = {1'b0, a} + DEPTH_W - {1'b0, b};
		r    = '0;
		case (op)
			ALU_ADD: begin
				if (sum >= DEPTH_W) begin
					r = AW'(sum - DEPTH_W);
				end else begin
					r = AW'(sum);
				end
			end
			ALU_SUB: begin
				// wrap back through the top of the ring
				if (a >= b) begin
					r = a - b;
				end else begin
					r = AW'(diff);
				end
			end
			default: r = '0;
		endcase
	end

endmodule
